// File: hdl/matrix3x3_inverse_macros.svh
// ----------------------------------------------------------------------------
// matrix3x3_inverse assertion macros
// Shorthand for clocked implications on the block's ports; the including
// module must provide clock and reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_MACROS_SVH
`define MATRIX3X3_INVERSE_MACROS_SVH

// same-cycle implication
`define M3I_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("m3i check failed");

// next-cycle implication
`define M3I_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("m3i check failed");

`endif

// File: hdl/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared constants, widths and types of the 3x3 matrix inverter.
// ----------------------------------------------------------------------------
package m3i_pkg;

   localparam int LANES       = 9;
   localparam int RES_BITS    = 32;
   localparam int QUOT_BITS   = 32;
   localparam int SCALE_SHIFT = 28;
   localparam int CSR_BITS    = 32;
   localparam int QDEPTH      = 16;
   localparam int QPTR_BITS   = $clog2(QDEPTH);
   localparam int QCNT_BITS   = QPTR_BITS + 1;

   // largest magnitudes that fit the signed result
   localparam logic [RES_BITS:0] POS_MAX = 33'h0_7FFF_FFFF;
   localparam logic [RES_BITS:0] NEG_MAX = 33'h0_8000_0000;

   typedef struct packed {
      logic nonempty;
      logic popped;
   } q_stat_type;

   function automatic int cof_bits(int e);
      return 2 * e + 1;
   endfunction

   function automatic int det_bits(int e);
      return 3 * e + 3;
   endfunction

   // queue word: cofactor magnitudes, per-lane sign, det magnitude, singular
   function automatic int entry_bits(int e);
      return LANES * (cof_bits(e) + 1) + det_bits(e) + 1;
   endfunction

endpackage

// File: hdl/m3i_front.sv
// ----------------------------------------------------------------------------
// m3i_front
// Accepts matrices, forms cofactors and determinant, classifies singular.
// ----------------------------------------------------------------------------
module m3i_front #(
   parameter int ELEMENT_BITS = 16
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             req_valid,
   output logic                                             req_stall,
   input  logic signed [ELEMENT_BITS-1:0]                   req_m00,
   input  logic signed [ELEMENT_BITS-1:0]                   req_m01,
   input  logic signed [ELEMENT_BITS-1:0]                   req_m02,
   input  logic signed [ELEMENT_BITS-1:0]                   req_m10,
   input  logic signed [ELEMENT_BITS-1:0]                   req_m11,
   input  logic signed [ELEMENT_BITS-1:0]                   req_m12,
   input  logic signed [ELEMENT_BITS-1:0]                   req_m20,
   input  logic signed [ELEMENT_BITS-1:0]                   req_m21,
   input  logic signed [ELEMENT_BITS-1:0]                   req_m22,
   input  logic                                             csr_write_enable,
   input  logic [m3i_pkg::CSR_BITS-1:0]                     csr_write_data,
   input  m3i_pkg::q_stat_type                              q_stat,
   output logic                                             push,
   output logic [m3i_pkg::entry_bits(ELEMENT_BITS)-1:0]     push_data
);
   import m3i_pkg::*;

   localparam int E    = ELEMENT_BITS;
   localparam int WC   = cof_bits(E);
   localparam int WD   = det_bits(E);
   localparam int QW   = entry_bits(E);
   localparam int CMPW = (WD > CSR_BITS) ? WD : CSR_BITS;
   localparam int NSTG = 6;

   // cofactor k = a[IX_A]*a[IX_B] - a[IX_C]*a[IX_D] (adjugate, row-major)
   localparam int IX_A [LANES] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int IX_B [LANES] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int IX_C [LANES] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int IX_D [LANES] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
   // first column feeds the determinant expansion
   localparam int IX_E [3]     = '{0, 3, 6};

   logic signed [E-1:0]    a [LANES];
   logic                   acc;

   logic [NSTG-1:0]        v_ff, v_in;
   logic [QCNT_BITS-1:0]   occ_ff, occ_in;
   logic [CSR_BITS-1:0]    limit_ff, limit_in;

   logic signed [2*E-1:0]  pa1_ff [LANES], pa1_in [LANES];
   logic signed [2*E-1:0]  pb1_ff [LANES], pb1_in [LANES];
   logic signed [E-1:0]    e1_ff [3], e1_in [3];
   logic signed [WC-1:0]   c2_ff [LANES], c2_in [LANES];
   logic signed [E-1:0]    e2_ff [3], e2_in [3];
   logic signed [2*E:0]    ph3_ff [3], ph3_in [3];
   logic signed [2*E:0]    pl3_ff [3], pl3_in [3];
   logic signed [WD-1:0]   t4_ff [3], t4_in [3];
   logic signed [WD-1:0]   det5_ff, det5_in;
   logic [WD-1:0]          dm6_ff, dm6_in;
   logic                   sg6_ff, sg6_in;
   logic [LANES-1:0]       ng6_ff, ng6_in;
   logic [WC-1:0]          cm3_ff [LANES], cm3_in [LANES];
   logic [WC-1:0]          cm4_ff [LANES], cm5_ff [LANES], cm6_ff [LANES];
   logic [LANES-1:0]       cs3_ff, cs3_in, cs4_ff, cs5_ff;

   assign a[0] = req_m00;
   assign a[1] = req_m01;
   assign a[2] = req_m02;
   assign a[3] = req_m10;
   assign a[4] = req_m11;
   assign a[5] = req_m12;
   assign a[6] = req_m20;
   assign a[7] = req_m21;
   assign a[8] = req_m22;

   // credit: every word in flight here or parked in the queue holds a slot
   assign req_stall = (occ_ff == QCNT_BITS'(QDEPTH));
   assign acc       = req_valid & ~req_stall;

   always_comb begin
      v_in     = {v_ff[NSTG-2:0], acc};
      occ_in   = occ_ff + QCNT_BITS'(acc) - QCNT_BITS'(q_stat.popped);
      limit_in = csr_write_enable ? csr_write_data : limit_ff;
      for (int k = 0; k < LANES; k++) begin
         pa1_in[k] = a[IX_A[k]] * a[IX_B[k]];
         pb1_in[k] = a[IX_C[k]] * a[IX_D[k]];
         c2_in[k]  = WC'(pa1_ff[k]) - WC'(pb1_ff[k]);
         cs3_in[k] = c2_ff[k][WC-1];
         cm3_in[k] = c2_ff[k][WC-1] ? WC'(-c2_ff[k]) : WC'(c2_ff[k]);
      end
      for (int j = 0; j < 3; j++) begin
         e1_in[j]  = a[IX_E[j]];
         e2_in[j]  = e1_ff[j];
         // cofactor split in a signed high half and an unsigned low half
         ph3_in[j] = $signed(c2_ff[j][WC-1:E]) * e2_ff[j];
         pl3_in[j] = $signed({1'b0, c2_ff[j][E-1:0]}) * e2_ff[j];
         t4_in[j]  = (WD'(ph3_ff[j]) <<< E) + WD'(pl3_ff[j]);
      end
      det5_in = t4_ff[0] + t4_ff[1] + t4_ff[2];
      dm6_in  = det5_ff[WD-1] ? WD'(-det5_ff) : WD'(det5_ff);
      sg6_in  = CMPW'(dm6_in) <= CMPW'(limit_ff);
      ng6_in  = cs5_ff ^ {LANES{det5_ff[WD-1]}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         occ_ff   <= '0;
         limit_ff <= '0;
      end else begin
         v_ff     <= v_in;
         occ_ff   <= occ_in;
         limit_ff <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      pa1_ff  <= pa1_in;
      pb1_ff  <= pb1_in;
      e1_ff   <= e1_in;
      c2_ff   <= c2_in;
      e2_ff   <= e2_in;
      ph3_ff  <= ph3_in;
      pl3_ff  <= pl3_in;
      cm3_ff  <= cm3_in;
      cs3_ff  <= cs3_in;
      t4_ff   <= t4_in;
      cm4_ff  <= cm3_ff;
      cs4_ff  <= cs3_ff;
      det5_ff <= det5_in;
      cm5_ff  <= cm4_ff;
      cs5_ff  <= cs4_ff;
      dm6_ff  <= dm6_in;
      sg6_ff  <= sg6_in;
      ng6_ff  <= ng6_in;
      cm6_ff  <= cm5_ff;
   end

   assign push = v_ff[NSTG-1];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         push_data[k*WC +: WC] = cm6_ff[k];
      end
      push_data[LANES*WC +: LANES]      = ng6_ff;
      push_data[LANES*(WC+1) +: WD]     = dm6_ff;
      push_data[QW-1]                   = sg6_ff;
   end

endmodule

// File: hdl/m3i_queue.sv
// ----------------------------------------------------------------------------
// m3i_queue
// Short FIFO between the classify front and the divide back.
// ----------------------------------------------------------------------------
module m3i_queue #(
   parameter int WIDTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [WIDTH-1:0]     push_data,
   input  logic                 pop,
   output logic [WIDTH-1:0]     pop_data,
   output m3i_pkg::q_stat_type  q_stat
);
   import m3i_pkg::*;

   logic [WIDTH-1:0]     mem_ff [QDEPTH];
   logic [QPTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_BITS-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff + QPTR_BITS'(push);
      rd_in  = rd_ff + QPTR_BITS'(pop);
      cnt_in = cnt_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign pop_data        = mem_ff[rd_ff];
   assign q_stat.nonempty = (cnt_ff != '0);
   assign q_stat.popped   = pop;

endmodule

// File: hdl/m3i_back.sv
// ----------------------------------------------------------------------------
// m3i_back
// Pipelined restoring divide of nine cofactors, rounding, saturation.
// ----------------------------------------------------------------------------
module m3i_back #(
   parameter int ELEMENT_BITS = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic [m3i_pkg::entry_bits(ELEMENT_BITS)-1:0] pop_data,
   input  m3i_pkg::q_stat_type                          q_stat,
   output logic                                         pop,
   output logic                                         rsp_valid,
   input  logic                                         rsp_stall,
   output logic signed [m3i_pkg::RES_BITS-1:0]          rsp_r00,
   output logic signed [m3i_pkg::RES_BITS-1:0]          rsp_r01,
   output logic signed [m3i_pkg::RES_BITS-1:0]          rsp_r02,
   output logic signed [m3i_pkg::RES_BITS-1:0]          rsp_r10,
   output logic signed [m3i_pkg::RES_BITS-1:0]          rsp_r11,
   output logic signed [m3i_pkg::RES_BITS-1:0]          rsp_r12,
   output logic signed [m3i_pkg::RES_BITS-1:0]          rsp_r20,
   output logic signed [m3i_pkg::RES_BITS-1:0]          rsp_r21,
   output logic signed [m3i_pkg::RES_BITS-1:0]          rsp_r22,
   output logic                                         rsp_singular,
   output logic                                         rsp_saturated
);
   import m3i_pkg::*;

   localparam int WC   = cof_bits(ELEMENT_BITS);
   localparam int WD   = det_bits(ELEMENT_BITS);
   localparam int QW   = entry_bits(ELEMENT_BITS);
   localparam int RW   = WD + 1;
   localparam int LEAD = QUOT_BITS - SCALE_SHIFT;
   localparam int NDIV = QUOT_BITS;

   logic                 en;
   logic [WC-1:0]        cm_q [LANES];
   logic [LANES-1:0]     ng_q;
   logic [WD-1:0]        dm_q;
   logic                 sg_q;

   // stage 0 is the entry stage, stages 1..NDIV each yield one quotient bit
   logic [RW-1:0]        r_ff [NDIV+1][LANES], r_in [NDIV+1][LANES];
   logic [QUOT_BITS-1:0] q_ff [NDIV+1][LANES], q_in [NDIV+1][LANES];
   logic [LEAD-1:0]      lo_ff [NDIV+1][LANES], lo_in [NDIV+1][LANES];
   logic [WD-1:0]        d_ff [NDIV+1], d_in [NDIV+1];
   logic [LANES-1:0]     ng_ff [NDIV+1], ng_in [NDIV+1];
   logic [LANES-1:0]     ov_ff [NDIV+1], ov_in [NDIV+1];
   logic [NDIV:0]        sg_ff, sg_in, vb_ff, vb_in;

   // rounding stage
   logic                 vr_ff, vr_in, sgr_ff, sgr_in;
   logic [LANES-1:0]     ngr_ff, ngr_in, str_ff, str_in;
   logic [RES_BITS-1:0]  mg_ff [LANES], mg_in [LANES];

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 sing_ff, sing_in, sat_ff, sat_in;
   logic [RES_BITS-1:0]  res_ff [LANES], res_in [LANES];

   assign en  = ~rsp_valid_ff | ~rsp_stall;
   assign pop = en & q_stat.nonempty;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         cm_q[k] = pop_data[k*WC +: WC];
      end
      ng_q = pop_data[LANES*WC +: LANES];
      dm_q = pop_data[LANES*(WC+1) +: WD];
      sg_q = pop_data[QW-1];
   end

   always_comb begin
      logic [RW-1:0]       rs;
      logic                ge;
      logic                rb;
      logic [RES_BITS:0]   qr;
      logic                over;

      // entry: quotient of |c|*2^28/D reaches 2^32 exactly when |c| >= D*2^LEAD
      vb_in[0] = pop;
      d_in[0]  = dm_q;
      ng_in[0] = ng_q;
      sg_in[0] = sg_q;
      for (int k = 0; k < LANES; k++) begin
         ov_in[0][k] = (WD+LEAD)'(cm_q[k]) >= {dm_q, {LEAD{1'b0}}};
         r_in[0][k]  = RW'(cm_q[k] >> LEAD);
         lo_in[0][k] = cm_q[k][LEAD-1:0];
         q_in[0][k]  = '0;
      end

      for (int s = 1; s <= NDIV; s++) begin
         vb_in[s] = vb_ff[s-1];
         d_in[s]  = d_ff[s-1];
         ng_in[s] = ng_ff[s-1];
         ov_in[s] = ov_ff[s-1];
         sg_in[s] = sg_ff[s-1];
         for (int k = 0; k < LANES; k++) begin
            rs          = {r_ff[s-1][k][RW-2:0], lo_ff[s-1][k][LEAD-1]};
            ge          = rs >= {1'b0, d_ff[s-1]};
            r_in[s][k]  = ge ? rs - {1'b0, d_ff[s-1]} : rs;
            q_in[s][k]  = {q_ff[s-1][k][QUOT_BITS-2:0], ge};
            lo_in[s][k] = {lo_ff[s-1][k][LEAD-2:0], 1'b0};
         end
      end

      // round half away from zero on the magnitude, then clip
      vr_in  = vb_ff[NDIV];
      sgr_in = sg_ff[NDIV];
      ngr_in = ng_ff[NDIV];
      for (int k = 0; k < LANES; k++) begin
         rb   = {r_ff[NDIV][k][RW-2:0], 1'b0} >= {1'b0, d_ff[NDIV]};
         qr   = {1'b0, q_ff[NDIV][k]} + (RES_BITS+1)'(rb);
         over = ng_ff[NDIV][k] ? (qr > NEG_MAX) : (qr > POS_MAX);
         str_in[k] = ov_ff[NDIV][k] | over;
         if (str_in[k]) begin
            mg_in[k] = ng_ff[NDIV][k] ? NEG_MAX[RES_BITS-1:0] : POS_MAX[RES_BITS-1:0];
         end else begin
            mg_in[k] = qr[RES_BITS-1:0];
         end
      end

      rsp_valid_in = vr_ff;
      sing_in      = sgr_ff;
      sat_in       = ~sgr_ff & (|str_ff);
      for (int k = 0; k < LANES; k++) begin
         if (sgr_ff) begin
            res_in[k] = '0;
         end else begin
            res_in[k] = ngr_ff[k] ? -mg_ff[k] : mg_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff        <= '0;
         vr_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vb_ff        <= vb_in;
         vr_ff        <= vr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff    <= r_in;
         q_ff    <= q_in;
         lo_ff   <= lo_in;
         d_ff    <= d_in;
         ng_ff   <= ng_in;
         ov_ff   <= ov_in;
         sg_ff   <= sg_in;
         sgr_ff  <= sgr_in;
         ngr_ff  <= ngr_in;
         str_ff  <= str_in;
         mg_ff   <= mg_in;
         sing_ff <= sing_in;
         sat_ff  <= sat_in;
         res_ff  <= res_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_singular  = sing_ff;
   assign rsp_saturated = sat_ff;
   assign rsp_r00       = res_ff[0];
   assign rsp_r01       = res_ff[1];
   assign rsp_r02       = res_ff[2];
   assign rsp_r10       = res_ff[3];
   assign rsp_r11       = res_ff[4];
   assign rsp_r12       = res_ff[5];
   assign rsp_r20       = res_ff[6];
   assign rsp_r21       = res_ff[7];
   assign rsp_r22       = res_ff[8];

endmodule

// File: hdl/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// 3x3 matrix inverse by adjugate over determinant, Q4.12 in, Q16.16 out.
// ----------------------------------------------------------------------------
//  channel  prefix  direction  word
//  request  req_    in         nine Q4.12 elements, row-major
//  result   rsp_    out        nine Q16.16 inverse elements, singular, saturated
//  csr      csr_    in         singular_limit, write only
//
//  One word per cycle sustained while rsp_stall stays low; the pipelined
//  divider takes a new word every cycle that the back is not stalled. A
//  word passes the front stages, the queue, the back stages (entry, 32
//  quotient steps, rounding) and then the output register.
//  Reset (synchronous) empties the queue and sets singular_limit to 0.
//  rsp_stall freezes the back pipeline; the front keeps accepting until the
//  16-word queue, counting words still in the front, is full.
// ----------------------------------------------------------------------------
module matrix3x3_inverse #(
   parameter int ELEMENT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [ELEMENT_BITS-1:0]      req_m00,
   input  logic signed [ELEMENT_BITS-1:0]      req_m01,
   input  logic signed [ELEMENT_BITS-1:0]      req_m02,
   input  logic signed [ELEMENT_BITS-1:0]      req_m10,
   input  logic signed [ELEMENT_BITS-1:0]      req_m11,
   input  logic signed [ELEMENT_BITS-1:0]      req_m12,
   input  logic signed [ELEMENT_BITS-1:0]      req_m20,
   input  logic signed [ELEMENT_BITS-1:0]      req_m21,
   input  logic signed [ELEMENT_BITS-1:0]      req_m22,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [m3i_pkg::RES_BITS-1:0] rsp_r00,
   output logic signed [m3i_pkg::RES_BITS-1:0] rsp_r01,
   output logic signed [m3i_pkg::RES_BITS-1:0] rsp_r02,
   output logic signed [m3i_pkg::RES_BITS-1:0] rsp_r10,
   output logic signed [m3i_pkg::RES_BITS-1:0] rsp_r11,
   output logic signed [m3i_pkg::RES_BITS-1:0] rsp_r12,
   output logic signed [m3i_pkg::RES_BITS-1:0] rsp_r20,
   output logic signed [m3i_pkg::RES_BITS-1:0] rsp_r21,
   output logic signed [m3i_pkg::RES_BITS-1:0] rsp_r22,
   output logic                                rsp_singular,
   output logic                                rsp_saturated,
   input  logic                                csr_write_enable,
   input  logic [m3i_pkg::CSR_BITS-1:0]        csr_write_data
);
   import m3i_pkg::*;

   localparam int QW = entry_bits(ELEMENT_BITS);

   // front -> queue
   logic          push;
   logic [QW-1:0] push_data;
   // queue -> back
   logic          pop;
   logic [QW-1:0] pop_data;
   q_stat_type    q_stat;

   // front: products, cofactors, determinant, singular test
   m3i_front #(.ELEMENT_BITS(ELEMENT_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_m00          (req_m00),
      .req_m01          (req_m01),
      .req_m02          (req_m02),
      .req_m10          (req_m10),
      .req_m11          (req_m11),
      .req_m12          (req_m12),
      .req_m20          (req_m20),
      .req_m21          (req_m21),
      .req_m22          (req_m22),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_stat           (q_stat),
      .push             (push),
      .push_data        (push_data)
   );

   // decoupling queue
   m3i_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_stat    (q_stat)
   );

   // back: nine divides sharing one determinant, stalled by rsp_stall
   m3i_back #(.ELEMENT_BITS(ELEMENT_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_data      (pop_data),
      .q_stat        (q_stat),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_r00       (rsp_r00),
      .rsp_r01       (rsp_r01),
      .rsp_r02       (rsp_r02),
      .rsp_r10       (rsp_r10),
      .rsp_r11       (rsp_r11),
      .rsp_r12       (rsp_r12),
      .rsp_r20       (rsp_r20),
      .rsp_r21       (rsp_r21),
      .rsp_r22       (rsp_r22),
      .rsp_singular  (rsp_singular),
      .rsp_saturated (rsp_saturated)
   );

endmodule

// File: hdl/m3i_checker.sv
// ----------------------------------------------------------------------------
// m3i_checker
// Port-level checks on the result channel of matrix3x3_inverse.
// ----------------------------------------------------------------------------
`include "matrix3x3_inverse_macros.svh"

module m3i_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [m3i_pkg::RES_BITS-1:0] rsp_r00,
   input logic signed [m3i_pkg::RES_BITS-1:0] rsp_r01,
   input logic signed [m3i_pkg::RES_BITS-1:0] rsp_r02,
   input logic signed [m3i_pkg::RES_BITS-1:0] rsp_r10,
   input logic signed [m3i_pkg::RES_BITS-1:0] rsp_r11,
   input logic signed [m3i_pkg::RES_BITS-1:0] rsp_r12,
   input logic signed [m3i_pkg::RES_BITS-1:0] rsp_r20,
   input logic signed [m3i_pkg::RES_BITS-1:0] rsp_r21,
   input logic signed [m3i_pkg::RES_BITS-1:0] rsp_r22,
   input logic                                rsp_singular,
   input logic                                rsp_saturated
);
   import m3i_pkg::*;

   logic [RES_BITS-1:0]         r [LANES];
   logic [LANES-1:0]            at_rail;
   logic                        all_zero;
   logic [LANES*RES_BITS+1:0]   rsp_word;

   assign r[0] = rsp_r00;
   assign r[1] = rsp_r01;
   assign r[2] = rsp_r02;
   assign r[3] = rsp_r10;
   assign r[4] = rsp_r11;
   assign r[5] = rsp_r12;
   assign r[6] = rsp_r20;
   assign r[7] = rsp_r21;
   assign r[8] = rsp_r22;

   // whole result word, for the hold check
   assign rsp_word = {rsp_r00, rsp_r01, rsp_r02, rsp_r10, rsp_r11, rsp_r12,
                      rsp_r20, rsp_r21, rsp_r22, rsp_singular, rsp_saturated};

   always_comb begin
      all_zero = 1'b1;
      for (int k = 0; k < LANES; k++) begin
         at_rail[k] = (r[k] == POS_MAX[RES_BITS-1:0]) || (r[k] == NEG_MAX[RES_BITS-1:0]);
         all_zero   = all_zero & (r[k] == '0);
      end
   end

   // a stalled word holds
   `M3I_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))
   // singular words are all zero and never clipped
   `M3I_ASSERT_IMP(a_sing_zero, rsp_valid && rsp_singular, all_zero && !rsp_saturated)
   // a clipped word has at least one element at a rail
   `M3I_ASSERT_IMP(a_sat_rail, rsp_valid && rsp_saturated, at_rail != '0)

endmodule

bind matrix3x3_inverse m3i_checker u_m3i_checker (.*);
